### design/mvt_pkg.sv
// shared types, codes and defaults for the matrix-vector transform unit
package mvt_pkg;

   // width of every element field on the ports
   localparam int unsigned FIELD_WIDTH = 32;
   // number of element fields one request or result carries
   localparam int unsigned SIDE = 4;

   // defaults for the top-level parameters
   localparam int unsigned DIM_DEFAULT        = 4;
   localparam int unsigned DATA_WIDTH_DEFAULT = 32;
   localparam int unsigned FRAC_BITS_DEFAULT  = 16;

   // register stages from request to result strobe
   localparam int unsigned LATENCY = 4;

   // function codes
   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_ROW  = 2'd1;
   localparam logic [1:0] FUNC_COL  = 2'd2;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]                    func;
      logic [1:0]                    row_sel;
      logic signed [FIELD_WIDTH-1:0] elem_0;
      logic signed [FIELD_WIDTH-1:0] elem_1;
      logic signed [FIELD_WIDTH-1:0] elem_2;
      logic signed [FIELD_WIDTH-1:0] elem_3;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] out_0;
      logic signed [FIELD_WIDTH-1:0] out_1;
      logic signed [FIELD_WIDTH-1:0] out_2;
      logic signed [FIELD_WIDTH-1:0] out_3;
   } rsp_type;

   // pick one element field of a request by position
   function automatic logic [FIELD_WIDTH-1:0] get_elem(input req_type r,
                                                       input int unsigned idx);
      logic [FIELD_WIDTH-1:0] e;
      case (idx)
         0: begin
            e = r.elem_0;
         end
         1: begin
            e = r.elem_1;
         end
         2: begin
            e = r.elem_2;
         end
         3: begin
            e = r.elem_3;
         end
         default: begin
            e = '0;
         end
      endcase
      return e;
   endfunction

endpackage

### design/mvt_matrix.sv
// matrix register file, one row written per load request
module mvt_matrix import mvt_pkg::*; #(
   parameter int unsigned DIM        = DIM_DEFAULT,
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [1:0]                   wr_row,
   input  logic signed [DATA_WIDTH-1:0] wr_data [DIM],
   output logic signed [DATA_WIDTH-1:0] mat [DIM][DIM]
);

   logic signed [DATA_WIDTH-1:0] mat_ff [DIM][DIM];

   // row write; rows beyond the dimension never match
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               mat_ff[r][c] <= '0;
            end
         end
      end else if (wr_en) begin
         for (int r = 0; r < DIM; r++) begin
            if (wr_row == 2'(r)) begin
               mat_ff[r] <= wr_data;
            end
         end
      end
   end

   assign mat = mat_ff;

endmodule

### design/mvt_lane.sv
// one dot-product lane: operand, multiply and sum register stages
module mvt_lane import mvt_pkg::*; #(
   parameter int unsigned DIM        = DIM_DEFAULT,
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT,
   localparam int unsigned PROD_WIDTH = 2 * DATA_WIDTH,
   localparam int unsigned SUM_WIDTH  = PROD_WIDTH + $clog2(DIM)
) (
   input  logic                         clock,
   input  logic signed [DATA_WIDTH-1:0] op_a [DIM],
   input  logic signed [DATA_WIDTH-1:0] op_b [DIM],
   output logic signed [SUM_WIDTH-1:0]  sum
);

   logic signed [DATA_WIDTH-1:0] op_a_ff [DIM];
   logic signed [DATA_WIDTH-1:0] op_b_ff [DIM];
   logic signed [PROD_WIDTH-1:0] prod_in [DIM];
   logic signed [PROD_WIDTH-1:0] prod_ff [DIM];
   logic signed [SUM_WIDTH-1:0]  sum_in;
   logic signed [SUM_WIDTH-1:0]  sum_ff;

   // full-width signed products, one multiplier per element
   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         prod_in[j] = op_a_ff[j] * op_b_ff[j];
      end
   end

   // exact sum of the products
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < DIM; j++) begin
         sum_in = sum_in + SUM_WIDTH'(prod_ff[j]);
      end
   end

   // payload pipeline, no reset needed
   always_ff @(posedge clock) begin
      op_a_ff <= op_a;
      op_b_ff <= op_b;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign sum = sum_ff;

endmodule

### design/mvt_merge.sv
// merge stage: scale, saturate and register the lane sums as one result
module mvt_merge import mvt_pkg::*; #(
   parameter int unsigned DIM        = DIM_DEFAULT,
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int unsigned FRAC_BITS  = FRAC_BITS_DEFAULT,
   localparam int unsigned SUM_WIDTH = 2 * DATA_WIDTH + $clog2(DIM)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic signed [SUM_WIDTH-1:0] sums [DIM],
   output logic                        rsp_valid,
   output rsp_type                     rsp_data
);

   localparam int unsigned TOP_WIDTH = SUM_WIDTH - DATA_WIDTH + 1;

   logic signed [SUM_WIDTH-1:0]   shifted [DIM];
   logic signed [DATA_WIDTH-1:0]  sat [DIM];
   logic signed [FIELD_WIDTH-1:0] out_vec [SIDE];
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   rsp_type                       rsp_data_ff;
   rsp_type                       rsp_data_in;

   // floor shift, then clamp to the data range
   always_comb begin
      logic [TOP_WIDTH-1:0] top;
      for (int k = 0; k < DIM; k++) begin
         shifted[k] = sums[k] >>> FRAC_BITS;
         top = shifted[k][SUM_WIDTH-1:DATA_WIDTH-1];
         if ((&top) || !(|top)) begin
            sat[k] = shifted[k][DATA_WIDTH-1:0];
         end else if (shifted[k][SUM_WIDTH-1]) begin
            sat[k] = {1'b1, {(DATA_WIDTH-1){1'b0}}};
         end else begin
            sat[k] = {1'b0, {(DATA_WIDTH-1){1'b1}}};
         end
      end
   end

   // lanes beyond the dimension read as zero
   always_comb begin
      for (int k = 0; k < SIDE; k++) begin
         out_vec[k] = '0;
      end
      for (int k = 0; k < DIM; k++) begin
         out_vec[k] = FIELD_WIDTH'(sat[k]);
      end
      rsp_data_in.out_0 = out_vec[0];
      rsp_data_in.out_1 = out_vec[1];
      rsp_data_in.out_2 = out_vec[2];
      rsp_data_in.out_3 = out_vec[3];
      rsp_valid_in      = in_valid;
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/matrix4_vector_transform_unit.sv
// Matrix-vector transform unit. A load request writes one matrix row; a
// multiply request returns the row vector times the matrix (func 1) or the
// matrix times the column vector (func 2) in signed fixed point, each
// element the exact sum of products shifted down by FRAC_BITS with floor
// rounding and saturated to DATA_WIDTH. busy stays low: a request is taken
// every cycle, and the result strobes on rsp_valid for one cycle, registered
// in turn by the operand, multiply, lane-sum and saturation registers.
// Results cannot be held off. A multiply sees every load taken in an earlier
// cycle. Load and unused function codes give no result.
module matrix4_vector_transform_unit import mvt_pkg::*; #(
   parameter int unsigned DIM        = DIM_DEFAULT,
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int unsigned FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int unsigned SUM_WIDTH = 2 * DATA_WIDTH + $clog2(DIM);

   logic                         accept;
   logic                         load_en;
   logic                         mult_en;
   logic [FIELD_WIDTH-1:0]       elem_raw [DIM];
   logic signed [DATA_WIDTH-1:0] vec [DIM];
   logic signed [DATA_WIDTH-1:0] mat [DIM][DIM];
   logic signed [DATA_WIDTH-1:0] op_a [DIM][DIM];
   logic signed [DATA_WIDTH-1:0] op_b [DIM][DIM];
   logic signed [SUM_WIDTH-1:0]  sums [DIM];
   logic [LATENCY-2:0]           valid_ff;
   logic [LATENCY-2:0]           valid_in;

   // request handshake
   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign load_en = accept && (req_data.func == FUNC_LOAD);
   assign mult_en = accept && ((req_data.func == FUNC_ROW) || (req_data.func == FUNC_COL));

   // elements narrowed to the data width
   for (genvar j = 0; j < DIM; j++) begin : g_elem
      assign elem_raw[j] = get_elem(req_data, j);
      assign vec[j]      = elem_raw[j][DATA_WIDTH-1:0];
   end

   mvt_matrix #(
      .DIM        (DIM),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_matrix (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_en),
      .wr_row  (req_data.row_sel),
      .wr_data (vec),
      .mat     (mat)
   );

   // lane operands: column of the matrix in row mode, row in column mode
   for (genvar i = 0; i < DIM; i++) begin : g_lane
      for (genvar j = 0; j < DIM; j++) begin : g_op
         assign op_a[i][j] = vec[j];
         assign op_b[i][j] = (req_data.func == FUNC_ROW) ? mat[j][i] : mat[i][j];
      end

      mvt_lane #(
         .DIM        (DIM),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_lane (
         .clock (clock),
         .op_a  (op_a[i]),
         .op_b  (op_b[i]),
         .sum   (sums[i])
      );
   end

   // valid tracking alongside the lane stages
   assign valid_in = {valid_ff[LATENCY-3:0], mult_en};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   mvt_merge #(
      .DIM        (DIM),
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[LATENCY-2]),
      .sums      (sums),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### design/mvt_checker.sv
// port-level checks for the transform unit, bound to the top level
module mvt_checker import mvt_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic mult_req;
   logic quiet_req;

   assign mult_req  = start && !busy &&
                      ((req_data.func == FUNC_ROW) || (req_data.func == FUNC_COL));
   assign quiet_req = start && !busy &&
                      ((req_data.func == FUNC_LOAD) || (req_data.func == FUNC_NONE));

   // every multiply request gets its result after the fixed latency
   a_mult_gives_result: assert property (@(posedge clock) disable iff (reset)
      mult_req |-> ##4 rsp_valid)
      else $error("multiply request without result");

   // a load or unused code produces no result
   a_quiet_no_result: assert property (@(posedge clock) disable iff (reset)
      quiet_req |-> ##4 !rsp_valid)
      else $error("result from a request that gives none");

   // no result appears without a multiply request before it
   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(mult_req, 4))
      else $error("result without a multiply request");

   // a strobed result carries known data
   a_result_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data))
      else $error("result data unknown while strobed");

endmodule

bind matrix4_vector_transform_unit mvt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
